// ===== hw/rtl/cdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CAP_W   = 5;
   localparam int unsigned CSR_A_W = 2;
   localparam int unsigned CSR_D_W = 32;

   localparam logic [CAP_W-1:0]   CAP_RESET    = 5'd16;
   localparam logic [CSR_A_W-1:0] CSR_CAPACITY = 2'd0;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam data_type NONE_VALUE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic clear;
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/cdq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_req_if
// Request channel: one deque operation per transfer.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   import cdq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// ===== hw/rtl/cdq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_rsp_if
// Response channel: result of one deque operation per transfer.
// ----------------------------------------------------------------------------
interface cdq_rsp_if;
   import cdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] pop_value;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] rear_value;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output pop_value, output status, output front_value,
                   output rear_value, output is_empty, output is_full, input ready);
   modport sink   (input valid, input pop_value, input status, input front_value,
                   input rear_value, input is_empty, input is_full, output ready);
endinterface

// ===== hw/rtl/cdq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell
// One element slot of the deque chain; shifts with its neighbours.
// ----------------------------------------------------------------------------
module cdq_cell
   import cdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  data_type     push_value,
   input  logic         left_valid,
   input  data_type     left_data,
   input  logic         right_valid,
   input  data_type     right_data,
   output logic         valid,
   output data_type     data,
   output data_type     rear_tap
);

   logic     valid_ff;
   logic     valid_in;
   data_type data_ff;
   data_type data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.push_front) begin
         valid_in = left_valid;
         data_in  = left_data;
      end else if (ctl.push_rear && !valid_ff && left_valid) begin
         valid_in = 1'b1;
         data_in  = push_value;
      end else if (ctl.pop_front) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (ctl.pop_rear && valid_ff && !right_valid) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid    = valid_ff;
   assign data     = data_ff;
   // last occupied cell presents the rear element
   assign rear_tap = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

// ===== hw/rtl/circular_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue with register-set capacity, built as a chain of cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | valid / ready        | operation, push_value
//  rsp     | out       | valid / ready        | pop_value, status, front_value,
//          |           |                      | rear_value, is_empty, is_full
//  csr     | in        | apb psel / penable   | capacity at byte address 0
//
//  the chain shifts in the transfer cycle; in the S_EVAL state that follows, the
//  rear element is gathered from the cells and the response is registered.
//  the front always sits in cell 0, the rear in the last occupied cell.
//  synchronous reset empties the deque and sets capacity to 16.
//  a stalled response holds the next evaluation; a request is taken while a
//  response waits, but not a second one.
// ----------------------------------------------------------------------------
module circular_deque
   import cdq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   cdq_req_if.sink             req,
   cdq_rsp_if.source           rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_A_W-1:0]  csr_paddr,
   input  logic [CSR_D_W-1:0]  csr_pwdata,
   output logic [CSR_D_W-1:0]  csr_prdata,
   output logic                csr_pready
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   state_type          state_ff;
   logic [CAP_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   cap_eff;
   data_type           pop_hold_ff;
   status_type         status_hold_ff;
   data_type           pop_hold_in;
   status_type         status_hold_in;

   logic               rsp_valid_ff;
   data_type           rsp_pop_ff;
   status_type         rsp_status_ff;
   data_type           rsp_front_ff;
   data_type           rsp_rear_ff;
   logic               rsp_empty_ff;
   logic               rsp_full_ff;

   logic               accept;
   logic               cfg_write;
   logic               push_ok;
   logic               pop_ok;
   op_type             op;
   cell_ctl_type       ctl;

   logic               cell_valid [DEPTH];
   data_type           cell_data  [DEPTH];
   data_type           cell_tap   [DEPTH];
   logic [DEPTH-1:0]   tap_col    [DATA_W];
   data_type           rear_any;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_CAPACITY);
   assign csr_prdata = (csr_paddr == CSR_CAPACITY) ? CSR_D_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (cfg_write) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(capacity_ff);
      end
   end

   // operation decode
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign op        = op_type'(req.operation);
   assign push_ok   = (count_ff < cap_eff);
   assign pop_ok    = (count_ff != '0);

   always_comb begin
      ctl            = '0;
      ctl.clear      = cfg_write;
      count_in       = count_ff;
      pop_hold_in    = NONE_VALUE;
      status_hold_in = ST_DONE;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (!push_ok) begin
               status_hold_in = ST_FULL;
            end else begin
               ctl.push_front = accept && (op == OP_PUSH_FRONT);
               ctl.push_rear  = accept && (op == OP_PUSH_REAR);
               count_in       = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (!pop_ok) begin
               status_hold_in = ST_EMPTY;
            end else begin
               ctl.pop_front = accept && (op == OP_POP_FRONT);
               ctl.pop_rear  = accept && (op == OP_POP_REAR);
               count_in      = count_ff - CNT_W'(1);
               pop_hold_in   = (op == OP_POP_FRONT) ? cell_data[0] : rsp_rear_ff;
            end
         end
         default: begin
            status_hold_in = ST_DONE;
         end
      endcase
   end

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     lv;
      data_type ld;
      logic     rv;
      data_type rd;
      if (i == 0) begin : g_first
         assign lv = 1'b1;
         assign ld = req.push_value;
      end else begin : g_mid
         assign lv = cell_valid[i-1];
         assign ld = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_inner
         assign rv = cell_valid[i+1];
         assign rd = cell_data[i+1];
      end
      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .push_value  (req.push_value),
         .left_valid  (lv),
         .left_data   (ld),
         .right_valid (rv),
         .right_data  (rd),
         .valid       (cell_valid[i]),
         .data        (cell_data[i]),
         .rear_tap    (cell_tap[i])
      );
      for (genvar b = 0; b < DATA_W; b++) begin : g_tap
         assign tap_col[b][i] = cell_tap[i][b];
      end
   end

   for (genvar b = 0; b < DATA_W; b++) begin : g_rear
      assign rear_any[b] = |tap_col[b];
   end

   // control and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != S_EVAL)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cfg_write) begin
                  count_ff <= '0;
               end else if (accept) begin
                  count_ff       <= count_in;
                  pop_hold_ff    <= pop_hold_in;
                  status_hold_ff <= status_hold_in;
                  state_ff       <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_pop_ff    <= pop_hold_ff;
                  rsp_status_ff <= status_hold_ff;
                  rsp_front_ff  <= (count_ff == '0) ? NONE_VALUE : cell_data[0];
                  rsp_rear_ff   <= (count_ff == '0) ? NONE_VALUE : rear_any;
                  rsp_empty_ff  <= (count_ff == '0);
                  rsp_full_ff   <= (count_ff == cap_eff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pop_value   = rsp_pop_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.front_value = rsp_front_ff;
   assign rsp.rear_value  = rsp_rear_ff;
   assign rsp.is_empty    = rsp_empty_ff;
   assign rsp.is_full     = rsp_full_ff;

endmodule

// ===== tb/sv/tb_circular_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular deque. A directed table covers the
// empty and full rejections, the value extremes, wrap of both ends and the
// capacity register limits. Random phases follow, at several capacities and
// with idle and stall patterns on both channels, including a long response
// hold-off that backs up the request side. Every response is checked against
// a behavioural copy of the deque in the bench, or its directed row's result.
// ----------------------------------------------------------------------------
module tb_circular_deque;
   import cdq_pkg::*;

   localparam int SLOTS     = 16;
   localparam int SLOT_W    = 4;
   localparam int LONG_HOLD = 300;
   localparam int NUM_PHASES = 8;

   typedef struct packed {
      data_type   pop_value;
      status_type status;
      data_type   front_value;
      data_type   rear_value;
      logic       is_empty;
      logic       is_full;
   } deque_result_type;

   typedef struct packed {
      logic             set_cap;
      logic [CAP_W-1:0] cap;
      op_type           op;
      data_type         value;
      logic             typed;
      deque_result_type result;
   } stim_row_type;

   logic clock;
   logic reset;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [CSR_A_W-1:0] csr_paddr;
   logic [CSR_D_W-1:0] csr_pwdata;
   logic [CSR_D_W-1:0] csr_prdata;
   logic               csr_pready;

   circular_deque #(.DEPTH(SLOTS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the deque
   data_type         slot_mem [SLOTS];
   logic [SLOT_W-1:0] head_slot;
   logic [SLOT_W-1:0] tail_slot;
   logic [CAP_W-1:0]  fill_count;
   logic [CAP_W-1:0]  cap_setting;

   deque_result_type pending_results [$];
   stim_row_type     directed_rows [$];

   logic             typed_flag;
   deque_result_type typed_result;

   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_orders;
   int failures;
   int count_push;
   int count_pop;
   int count_full;
   int count_empty;
   int cap_writes;

   deque_result_type seen_want;
   deque_result_type seen_next;

   function automatic deque_result_type result_of(data_type pop_value, status_type status,
                                                  data_type front_value, data_type rear_value,
                                                  logic is_empty, logic is_full);
      deque_result_type r;
      r.pop_value   = pop_value;
      r.status      = status;
      r.front_value = front_value;
      r.rear_value  = rear_value;
      r.is_empty    = is_empty;
      r.is_full     = is_full;
      return r;
   endfunction

   function automatic deque_result_type apply_deque_op(op_type op, data_type value);
      deque_result_type r;
      logic [CAP_W-1:0] cap_eff;
      logic [CAP_W-1:0] wrap_top;
      logic [CAP_W-1:0] next_slot;
      if (cap_setting == '0) begin
         cap_eff = 5'd1;
      end else if (32'(cap_setting) > SLOTS) begin
         cap_eff = 5'd16;
      end else begin
         cap_eff = cap_setting;
      end
      wrap_top    = cap_eff - 5'd1;
      r.pop_value = NONE_VALUE;
      r.status    = ST_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
         if (fill_count >= cap_eff) begin
            r.status = ST_FULL;
         end else begin
            if (fill_count == '0) begin
               head_slot   = '0;
               tail_slot   = '0;
               slot_mem[0] = value;
            end else if (op == OP_PUSH_FRONT) begin
               head_slot = (head_slot == '0) ? wrap_top[SLOT_W-1:0] : head_slot - SLOT_W'(1);
               slot_mem[head_slot] = value;
            end else begin
               next_slot = {1'b0, tail_slot} + 5'd1;
               tail_slot = (next_slot >= cap_eff) ? '0 : next_slot[SLOT_W-1:0];
               slot_mem[tail_slot] = value;
            end
            fill_count = fill_count + 5'd1;
         end
      end else if (fill_count == '0) begin
         r.status = ST_EMPTY;
      end else begin
         if (op == OP_POP_FRONT) begin
            r.pop_value = slot_mem[head_slot];
            next_slot   = {1'b0, head_slot} + 5'd1;
            head_slot   = (next_slot >= cap_eff) ? '0 : next_slot[SLOT_W-1:0];
         end else begin
            r.pop_value = slot_mem[tail_slot];
            tail_slot   = (tail_slot == '0) ? wrap_top[SLOT_W-1:0] : tail_slot - SLOT_W'(1);
         end
         fill_count = fill_count - 5'd1;
         if (fill_count == '0) begin
            head_slot = '0;
            tail_slot = '0;
         end
      end
      if (fill_count == '0) begin
         r.front_value = NONE_VALUE;
         r.rear_value  = NONE_VALUE;
      end else begin
         r.front_value = slot_mem[head_slot];
         r.rear_value  = slot_mem[tail_slot];
      end
      r.is_empty = (fill_count == '0);
      r.is_full  = (fill_count == cap_eff);
      return r;
   endfunction

   function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // response side: random stalls plus the long hold-off on request
   initial begin : receiver
      int hold_served;
      int hold_count;
      hold_served  = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) begin
               rsp_ch.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // checks responses, then books the expectation for a new request transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("response transfer with nothing expected");
               failures++;
            end else begin
               seen_want = pending_results.pop_front();
               failures += field_mismatch("pop_value", seen_want.pop_value, rsp_ch.pop_value);
               failures += field_mismatch("status", 32'(seen_want.status),
                                          32'(rsp_ch.status));
               failures += field_mismatch("front_value", seen_want.front_value,
                                          rsp_ch.front_value);
               failures += field_mismatch("rear_value", seen_want.rear_value,
                                          rsp_ch.rear_value);
               failures += field_mismatch("is_empty", 32'(seen_want.is_empty),
                                          32'(rsp_ch.is_empty));
               failures += field_mismatch("is_full", 32'(seen_want.is_full),
                                          32'(rsp_ch.is_full));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen_next = apply_deque_op(op_type'(req_ch.operation), req_ch.push_value);
            case (seen_next.status)
               ST_FULL:  count_full++;
               ST_EMPTY: count_empty++;
               default: begin
                  if (req_ch.operation == OP_PUSH_FRONT || req_ch.operation == OP_PUSH_REAR) begin
                     count_push++;
                  end else begin
                     count_pop++;
                  end
               end
            endcase
            pending_results.push_back(typed_flag ? typed_result : seen_next);
         end
      end
   end

   task automatic send_op(op_type op, data_type value, logic typed, deque_result_type result);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.push_value <= value;
      typed_flag        <= typed;
      typed_result      <= result;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         failures++;
         pending_results.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_read_check(logic [CSR_D_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_CAPACITY;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      failures += field_mismatch("capacity", want, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_CAPACITY;
      csr_pwdata  <= {{(CSR_D_W-CAP_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cap_setting = value;
      fill_count  = '0;
      head_slot   = '0;
      tail_slot   = '0;
      cap_writes++;
      @(negedge clock);
      csr_read_check({{(CSR_D_W-CAP_W){1'b0}}, value});
   endtask

   task automatic add_row(logic set_cap, logic [CAP_W-1:0] cap, op_type op, data_type value,
                          logic typed, deque_result_type result);
      stim_row_type row;
      row.set_cap = set_cap;
      row.cap     = cap;
      row.op      = op;
      row.value   = value;
      row.typed   = typed;
      row.result  = result;
      directed_rows.push_back(row);
   endtask

   initial begin : stimulus
      int phase_cap   [NUM_PHASES] = '{16, 1, 31, 0, 3, 7, 16, 12};
      int phase_idle  [NUM_PHASES] = '{0, 70, 0, 9, 0, 70, 0, 9};
      int phase_stall [NUM_PHASES] = '{0, 0, 70, 9, 0, 0, 70, 9};
      int phase_items [NUM_PHASES] = '{250, 150, 250, 150, 200, 200, 200, 200};
      deque_result_type no_result;
      int phase;
      int n;
      int run_left;
      int guard;
      logic push_mood;
      op_type op;
      data_type value;

      no_result          = '0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_PUSH_FRONT;
      req_ch.push_value  = '0;
      typed_flag         = 1'b0;
      typed_result       = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_orders        = 0;
      failures           = 0;
      count_push         = 0;
      count_pop          = 0;
      count_full         = 0;
      count_empty        = 0;
      cap_writes         = 0;
      cap_setting        = CAP_RESET;
      fill_count         = '0;
      head_slot          = '0;
      tail_slot          = '0;
      foreach (slot_mem[i]) slot_mem[i] = '0;

      // empty start, extremes, drain to empty
      add_row(1'b0, 5'd0, OP_POP_FRONT, 32'h0000_0000, 1'b1,
              result_of(NONE_VALUE, ST_EMPTY, NONE_VALUE, NONE_VALUE, 1'b1, 1'b0));
      add_row(1'b0, 5'd0, OP_POP_REAR, 32'h7FFF_FFFF, 1'b1,
              result_of(NONE_VALUE, ST_EMPTY, NONE_VALUE, NONE_VALUE, 1'b1, 1'b0));
      add_row(1'b0, 5'd0, OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
              result_of(NONE_VALUE, ST_DONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_row(1'b0, 5'd0, OP_PUSH_REAR, 32'h8000_0000, 1'b1,
              result_of(NONE_VALUE, ST_DONE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0));
      add_row(1'b0, 5'd0, OP_PUSH_FRONT, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_PUSH_REAR, 32'hFFFF_FFFF, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_FRONT, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_REAR, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_REAR, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_FRONT, 32'h0000_0000, 1'b1,
              result_of(32'h7FFF_FFFF, ST_DONE, NONE_VALUE, NONE_VALUE, 1'b1, 1'b0));
      // capacity zero behaves as one slot
      add_row(1'b1, 5'd0, OP_PUSH_REAR, 32'h5A5A_5A5A, 1'b1,
              result_of(NONE_VALUE, ST_DONE, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b0, 1'b1));
      add_row(1'b0, 5'd0, OP_PUSH_FRONT, 32'h0000_0001, 1'b1,
              result_of(NONE_VALUE, ST_FULL, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b0, 1'b1));
      add_row(1'b0, 5'd0, OP_POP_REAR, 32'h0000_0000, 1'b1,
              result_of(32'h5A5A_5A5A, ST_DONE, NONE_VALUE, NONE_VALUE, 1'b1, 1'b0));
      // two slots: wrap at both ends
      add_row(1'b1, 5'd2, OP_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_PUSH_FRONT, 32'h1234_5678, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_PUSH_REAR, 32'h0000_0003, 1'b1,
              result_of(NONE_VALUE, ST_FULL, 32'h1234_5678, 32'hA5A5_A5A5, 1'b0, 1'b1));
      add_row(1'b0, 5'd0, OP_POP_REAR, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_PUSH_REAR, 32'h8765_4321, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_FRONT, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_FRONT, 32'h0000_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_POP_FRONT, 32'h0000_0000, 1'b1,
              result_of(NONE_VALUE, ST_EMPTY, NONE_VALUE, NONE_VALUE, 1'b1, 1'b0));
      // capacity above the built depth, then a write that empties a filled deque
      add_row(1'b1, 5'd31, OP_PUSH_REAR, 32'hFFFF_0000, 1'b0, no_result);
      add_row(1'b0, 5'd0, OP_PUSH_FRONT, 32'h0000_FFFF, 1'b0, no_result);
      add_row(1'b1, 5'd5, OP_POP_FRONT, 32'h0000_0000, 1'b1,
              result_of(NONE_VALUE, ST_EMPTY, NONE_VALUE, NONE_VALUE, 1'b1, 1'b0));
      add_row(1'b0, 5'd0, OP_PUSH_REAR, 32'hDEAD_BEEF, 1'b0, no_result);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_read_check({{(CSR_D_W-CAP_W){1'b0}}, CAP_RESET});

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_cap) begin
            set_capacity(directed_rows[i].cap);
         end
         send_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                 directed_rows[i].result);
      end

      // random phases: runs of pushes and runs of pops so both ends fill and drain
      push_mood = 1'b1;
      run_left  = 0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         set_capacity(CAP_W'(phase_cap[phase]));
         sender_idle_pct    = phase_idle[phase];
         receiver_stall_pct = phase_stall[phase];
         if (phase == 2) begin
            hold_orders++;
         end
         for (n = 0; n < phase_items[phase]; n++) begin
            if (run_left == 0) begin
               push_mood = ~push_mood;
               run_left  = $urandom_range(1, 40);
            end
            run_left--;
            if (($urandom_range(99) < 85) == push_mood) begin
               op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            end else begin
               op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
            end
            case ($urandom_range(9))
               0:       value = 32'h0000_0000;
               1:       value = 32'hFFFF_FFFF;
               2:       value = 32'h7FFF_FFFF;
               3:       value = 32'h8000_0000;
               default: value = $urandom;
            endcase
            send_op(op, value, 1'b0, no_result);
         end
      end

      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         failures++;
      end
      repeat (10) @(negedge clock);

      $display("covered %0d pushes, %0d pops, %0d full and %0d empty rejections",
               count_push, count_pop, count_full, count_empty);
      $display("over %0d capacity writes with idle, stall and hold-off patterns", cap_writes);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
